@@ src/sbq_pkg.sv @@
`default_nettype none
package sbq_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 32;
  localparam int COEF_FRAC_BITS = 28;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 3;

  // A 32 x 24 signed product, and five of them summed without wrapping.
  localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam int Q_BITS    = ACC_BITS - COEF_FRAC_BITS;

  // Five products, one per cycle, plus a final step that adds the last one.
  localparam int MAC_TERMS = 5;
  localparam int STEP_BITS = 3;

  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [Q_BITS-1:0] Q_SAT_MAX =
    Q_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [Q_BITS-1:0] Q_SAT_MIN = -Q_SAT_MAX - Q_BITS'(1);

  localparam logic signed [COEF_BITS-1:0] COEF_B0_RESET = COEF_BITS'(268435456);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLE = 3'd0,
    REG_B0     = 3'd1,
    REG_B1     = 3'd2,
    REG_B2     = 3'd3,
    REG_A1     = 3'd4,
    REG_A2     = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] b1;
    logic signed [COEF_BITS-1:0] b2;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } coef_set_t;

  typedef struct packed {
    logic                          idle;
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] y;
  } lane_status_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } pass_req_t;

endpackage
`default_nettype wire

@@ src/sbq_stream_if.sv @@
`default_nettype none
interface sbq_sample_if;
  import sbq_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sbq_result_if;
  import sbq_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

@@ src/sbq_lane.sv @@
`default_nettype none
module sbq_lane (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [sbq_pkg::SAMPLE_BITS-1:0] x,
  input  wire sbq_pkg::coef_set_t                    coef,
  input  wire logic                                  ack,
  output sbq_pkg::lane_status_t                      status
);
  import sbq_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE  = 4'b0001,
    L_MAC   = 4'b0010,
    L_ROUND = 4'b0100,
    L_HOLD  = 4'b1000
  } lane_state_t;

  lane_state_t                   state;
  logic [STEP_BITS-1:0]          step;
  logic signed [SAMPLE_BITS-1:0] x_cur, x1, x2, y1, y2, y_reg;
  logic signed [PROD_BITS-1:0]   prod;
  logic                          prod_sub;
  logic signed [ACC_BITS-1:0]    acc;

  logic signed [COEF_BITS-1:0]   coef_sel;
  logic signed [SAMPLE_BITS-1:0] op_sel;
  logic signed [PROD_BITS-1:0]   prod_next;
  logic signed [ACC_BITS-1:0]    rsum;
  logic signed [Q_BITS-1:0]      q;
  logic signed [SAMPLE_BITS-1:0] y_next;

  always_comb begin
    case (step)
      3'd0: begin coef_sel = coef.b0; op_sel = x_cur; end
      3'd1: begin coef_sel = coef.b1; op_sel = x1;    end
      3'd2: begin coef_sel = coef.b2; op_sel = x2;    end
      3'd3: begin coef_sel = coef.a1; op_sel = y1;    end
      default: begin coef_sel = coef.a2; op_sel = y2; end
    endcase
    prod_next = coef_sel * op_sel;
  end

  // Round half up at the binary point, then clamp to the sample range.
  always_comb begin
    rsum = acc + ROUND_HALF;
    q    = rsum[ACC_BITS-1:COEF_FRAC_BITS];
    if (q > Q_SAT_MAX) begin
      y_next = Q_SAT_MAX[SAMPLE_BITS-1:0];
    end else if (q < Q_SAT_MIN) begin
      y_next = Q_SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_next = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      step  <= '0;
      x1    <= '0;
      x2    <= '0;
      y1    <= '0;
      y2    <= '0;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (start) begin
            x_cur <= x;
            step  <= '0;
            state <= L_MAC;
          end
        end
        L_MAC: begin
          prod     <= prod_next;
          prod_sub <= (step >= 3'd3);
          if (step == '0) begin
            acc <= '0;
          end else if (prod_sub) begin
            acc <= acc - ACC_BITS'(prod);
          end else begin
            acc <= acc + ACC_BITS'(prod);
          end
          if (step == STEP_BITS'(MAC_TERMS)) begin
            state <= L_ROUND;
          end
          step <= step + 3'd1;
        end
        L_ROUND: begin
          y_reg <= y_next;
          x2    <= x1;
          x1    <= x_cur;
          y2    <= y1;
          y1    <= y_next;
          state <= L_HOLD;
        end
        L_HOLD: begin
          if (ack) begin
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign status.idle  = (state == L_IDLE);
  assign status.valid = (state == L_HOLD);
  assign status.y     = y_reg;

endmodule
`default_nettype wire

@@ src/sbq_merge.sv @@
`default_nettype none
module sbq_merge (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sbq_pkg::lane_status_t left,
  input  wire sbq_pkg::lane_status_t right,
  input  wire sbq_pkg::pass_req_t    pass,
  output logic                       lane_ack,
  output logic                       pass_ack,
  sbq_result_if.source               result
);
  import sbq_pkg::*;

  logic out_valid;
  logic load_ok;

  assign load_ok  = !out_valid || result.ready;
  assign lane_ack = left.valid && right.valid && load_ok;
  assign pass_ack = pass.valid && !left.valid && load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lane_ack || pass_ack) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_ack) begin
      result.left_out  <= left.y;
      result.right_out <= right.y;
    end else if (pass_ack) begin
      result.left_out  <= pass.left;
      result.right_out <= pass.right;
    end
  end

  assign result.valid = out_valid;

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    left.valid == right.valid)
    else $error("left and right lanes finished in different cycles");

  a_no_pass_while_filtering: assert property (@(posedge clk) disable iff (rst)
    !(pass.valid && (left.valid || !left.idle)))
    else $error("pass-through requested while the lanes hold work");

  a_lane_result_loaded: assert property (@(posedge clk) disable iff (rst)
    lane_ack |=> (out_valid && result.left_out == $past(left.y)
                  && result.right_out == $past(right.y)))
    else $error("lane result not loaded into the output register");

endmodule
`default_nettype wire

@@ src/stereo_biquad_filter.sv @@
`default_nettype none
// When filtering, pairs go from the input buffer through both lanes to the merge
// output register, paced by the lane MAC (five products through one multiplier
// per lane, then rounding), with no new pair until the lanes are idle. When
// disabled, pairs go from the buffer straight to the output register, one per
// cycle unless the output stalls. Synchronous active-high reset clears the
// histories, disables the filter, sets b0 to unity gain and the rest to zero.
module stereo_biquad_filter (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     cfg_write,
  input  wire logic [sbq_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  wire logic [sbq_pkg::CFG_DATA_BITS-1:0]        cfg_data,
  sbq_sample_if.sink                                    sample_in,
  sbq_result_if.source                                  result_out
);
  import sbq_pkg::*;

  // Configuration registers. User rule: writes arrive only while no pair is in flight; not enforced.
  logic      filter_enable;
  coef_set_t coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable <= 1'b0;
      coef.b0       <= COEF_B0_RESET;
      coef.b1       <= '0;
      coef.b2       <= '0;
      coef.a1       <= '0;
      coef.a2       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ENABLE: filter_enable <= cfg_data[0];
        REG_B0:     coef.b0       <= cfg_data[COEF_BITS-1:0];
        REG_B1:     coef.b1       <= cfg_data[COEF_BITS-1:0];
        REG_B2:     coef.b2       <= cfg_data[COEF_BITS-1:0];
        REG_A1:     coef.a1       <= cfg_data[COEF_BITS-1:0];
        REG_A2:     coef.a2       <= cfg_data[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  // One-entry input buffer. It takes a new transfer in the same cycle that
  // its current pair is handed to the lanes or to the pass-through path, so
  // pairs can arrive back to back; the source is held back only while the
  // buffered pair cannot move on because the lanes or the output are busy.
  logic                          in_full;
  logic signed [SAMPLE_BITS-1:0] in_left, in_right;
  logic                          start;
  logic                          dispatch;
  logic                          in_take;

  lane_status_t left_status, right_status;
  pass_req_t    pass;
  logic         lane_ack, pass_ack;

  assign start    = in_full && filter_enable && left_status.idle;
  assign dispatch = start || pass_ack;
  assign sample_in.ready = !in_full || dispatch;
  assign in_take  = sample_in.valid && sample_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (dispatch) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_left  <= sample_in.left_sample;
      in_right <= sample_in.right_sample;
    end
  end

  // When disabled the pair skips the lanes entirely and the histories stay.
  assign pass.valid = in_full && !filter_enable;
  assign pass.left  = in_left;
  assign pass.right = in_right;

  // Two identical lanes, one per channel, share the coefficient set and run
  // in lockstep; the merge stage joins their results into one transfer.
  sbq_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .x      (in_left),
    .coef   (coef),
    .ack    (lane_ack),
    .status (left_status)
  );

  sbq_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .x      (in_right),
    .coef   (coef),
    .ack    (lane_ack),
    .status (right_status)
  );

  sbq_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .left     (left_status),
    .right    (right_status),
    .pass     (pass),
    .lane_ack (lane_ack),
    .pass_ack (pass_ack),
    .result   (result_out)
  );

endmodule
`default_nettype wire

@@ bench/stereo_biquad_filter_tb.sv @@
module stereo_biquad_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbq_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // One stereo pair, as it goes in and as it comes out.
  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  // Delay line of one channel: the last two inputs and the last two outputs.
  typedef struct {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } tap_hist_t;

  // Register indexes that the block does not decode.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  localparam sample_t SAMPLE_MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t   COEF_MAX     = 32'h7FFF_FFFF;
  localparam coef_t   COEF_MIN     = 32'h8000_0000;
  localparam longint  ROUND_HALF_WIDE = longint'(1) <<< (COEF_FRAC_BITS - 1);

  // Cycles without any transfer or register write before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  sbq_sample_if sample_ch ();
  sbq_result_if result_ch ();

  stereo_biquad_filter uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_ch),
    .result_out (result_ch)
  );

  // Shadow copy of the block's registers and delay lines.
  logic      filter_on;
  coef_t     b0, b1, b2, a1, a2;
  tap_hist_t left_hist, right_hist;

  // Filtered pairs that the block still owes us, oldest first.
  stereo_t pending_outputs[$];

  int error_count;
  int quiet_cycles;
  bit jitter_on;
  int sink_hold_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One direct form I step for one channel. The five products are summed in a
  // 64-bit accumulator, which holds the worst case of five 32 x 24 products
  // without wrapping. Rounding is half up: add half an LSB, then shift right
  // arithmetically, which floors. The saturated value is what enters the
  // output delay line.
  function automatic sample_t filter_channel(input sample_t x, inout tap_hist_t h);
    longint acc;
    longint q;
    acc = longint'(b0) * longint'(x)
        + longint'(b1) * longint'(h.x1)
        + longint'(b2) * longint'(h.x2)
        - longint'(a1) * longint'(h.y1)
        - longint'(a2) * longint'(h.y2);
    q = (acc + ROUND_HALF_WIDE) >>> COEF_FRAC_BITS;
    if (q > longint'(SAMPLE_MAX_S)) q = longint'(SAMPLE_MAX_S);
    if (q < longint'(SAMPLE_MIN_S)) q = longint'(SAMPLE_MIN_S);
    h.x2 = h.x1;
    h.x1 = x;
    h.y2 = h.y1;
    h.y1 = sample_t'(q);
    return sample_t'(q);
  endfunction

  // With the filter off the pair passes through and the delay lines are left
  // exactly as they were, so filtering picks up where it stopped.
  function automatic stereo_t filter_pair(input stereo_t pair_in);
    stereo_t pair_out;
    if (!filter_on) return pair_in;
    pair_out.left  = filter_channel(pair_in.left, left_hist);
    pair_out.right = filter_channel(pair_in.right, right_hist);
    return pair_out;
  endfunction

  // Only the register's own width counts; the enable looks at bit 0 alone and
  // writes to undecoded indexes change nothing.
  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] index,
                                    input logic [CFG_DATA_BITS-1:0] data);
    case (index)
      REG_ENABLE: filter_on = data[0];
      REG_B0:     b0 = coef_t'(data);
      REG_B1:     b1 = coef_t'(data);
      REG_B2:     b2 = coef_t'(data);
      REG_A1:     a1 = coef_t'(data);
      REG_A2:     a2 = coef_t'(data);
      default: ;
    endcase
  endfunction

  function automatic void log_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly full-range values, with the two rails and small values near zero
  // mixed in so that rounding and saturation are hit often.
  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX_S;
      1:       return SAMPLE_MIN_S;
      2:       return sample_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Coefficients are mostly within +-1.0 so that the output does not always
  // sit on a rail, but the full Q3.28 range and its ends show up as well.
  function automatic coef_t random_coef();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      1:       return '0;
      2:       return coef_t'($urandom);
      default: return coef_t'($signed($urandom) >>> 3);
    endcase
  endfunction

  // Offers one pair and waits for the transfer. The expected output is
  // computed at the very edge the pair is taken, so it sees exactly the
  // registers and delay lines the block sees. Called and left at a falling
  // edge; valid is only lowered when an idle gap follows.
  task automatic send_pair(input sample_t left, input sample_t right);
    stereo_t pair;
    int gap;
    pair.left  = left;
    pair.right = right;
    sample_ch.valid        <= 1'b1;
    sample_ch.left_sample  <= left;
    sample_ch.right_sample <= right;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    pending_outputs.push_back(filter_pair(pair));
    @(negedge clk);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stops offering pairs and waits until every owed result has come back,
  // which leaves the block idle for register writes.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_outputs.size() != 0);
  endtask

  // One register write. The write enable drops for a cycle afterwards so that
  // back-to-back writes never raise and lower it in the same step.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    apply_reg(index, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_coefs(input coef_t c_b0, input coef_t c_b1, input coef_t c_b2,
                            input coef_t c_a1, input coef_t c_a2);
    write_reg(REG_B0, c_b0);
    write_reg(REG_B1, c_b1);
    write_reg(REG_B2, c_b2);
    write_reg(REG_A1, c_a1);
    write_reg(REG_A2, c_a2);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the filter is off: the rails and alternating bit patterns
  // must come out unchanged.
  task automatic test_reset_passthrough();
    send_pair(SAMPLE_MAX_S, SAMPLE_MIN_S);
    send_pair(SAMPLE_MIN_S, SAMPLE_MAX_S);
    send_pair('0, '1);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(24'hAAAAAA, 24'h555555);
  endtask

  // The reset coefficients are unity gain on b0 alone, so turning the filter
  // on must still give the input back, rails included.
  task automatic test_unity_gain();
    drain_results();
    write_reg(REG_ENABLE, 32'h0000_0001);
    send_pair(SAMPLE_MAX_S, SAMPLE_MIN_S);
    send_pair(SAMPLE_MIN_S, SAMPLE_MAX_S);
    send_pair(24'sd1, -24'sd1);
  endtask

  // A gain of one half puts odd inputs exactly on the half LSB: +0.5 rounds
  // up to 1, -0.5 rounds up to 0, +1.5 to 2 and -1.5 to -1.
  task automatic test_round_half_up();
    drain_results();
    write_reg(REG_B0, 32'h0800_0000);
    send_pair(24'sd1, -24'sd1);
    send_pair(24'sd3, -24'sd3);
    send_pair('0, SAMPLE_MAX_S);
  endtask

  // Every coefficient at a rail and every sample at a rail: the wide sum must
  // not wrap, and the result must clamp at both ends.
  task automatic test_saturation();
    drain_results();
    load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
    send_pair(SAMPLE_MAX_S, SAMPLE_MIN_S);
    send_pair(SAMPLE_MAX_S, SAMPLE_MIN_S);
    send_pair(SAMPLE_MIN_S, SAMPLE_MAX_S);
    drain_results();
    load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
    send_pair(SAMPLE_MIN_S, SAMPLE_MAX_S);
  endtask

  // Builds up some history, switches the filter off with all upper data bits
  // set (only bit 0 counts), passes samples through, and switches it back on
  // with bit 1 set too. The first filtered outputs after that depend on the
  // history from before the pause.
  task automatic test_history_across_bypass();
    drain_results();
    // 0.25, 0.5, 0.25 feedforward; feedback a1 = -0.5, a2 = 0.125.
    load_coefs(32'h0400_0000, 32'h0800_0000, 32'h0400_0000,
               32'hF800_0000, 32'h0200_0000);
    send_pair(24'sd1000000, -24'sd2000000);
    send_pair(24'sd3000000, SAMPLE_MAX_S);
    drain_results();
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    send_pair(-24'sd12345, 24'sd777);
    send_pair(SAMPLE_MIN_S, 24'sd1);
    drain_results();
    write_reg(REG_ENABLE, 32'h0000_0003);
    send_pair('0, '0);
    send_pair('0, '0);
  endtask

  // Writes to the two undecoded indexes must leave every register alone.
  task automatic test_spare_indexes();
    drain_results();
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    send_pair(24'sd4096, -24'sd4096);
    send_pair(random_sample(), random_sample());
  endtask

  // The receiver stops for a long stretch while the sender keeps offering
  // pairs back to back, so the block fills up and must stall its input.
  task automatic test_output_backpressure();
    drain_results();
    load_coefs(random_coef(), random_coef(), random_coef(), random_coef(), random_coef());
    jitter_on = 1'b0;
    sink_hold_cycles = 150;
    repeat (30) send_pair(random_sample(), random_sample());
  endtask

  // The sender goes quiet until every result is back, then resumes.
  task automatic test_sender_pause();
    jitter_on = 1'b1;
    repeat (5) send_pair(random_sample(), random_sample());
    drain_results();
    repeat (5) send_pair(random_sample(), random_sample());
  endtask

  // Random phases, each with a fresh register setting. The first two phases
  // put every coefficient on one rail; one phase runs with the filter off.
  task automatic test_random_phases();
    logic enable_bit;
    for (int phase = 0; phase < 10; phase++) begin
      drain_results();
      case (phase)
        0:       load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        1:       load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        default: load_coefs(random_coef(), random_coef(), random_coef(),
                            random_coef(), random_coef());
      endcase
      enable_bit = (phase != 4);
      write_reg(REG_ENABLE, {31'($urandom), enable_bit});
      jitter_on = 1'b1;
      repeat (105) send_pair(random_sample(), random_sample());
    end
  endtask

  // Last stretch at full speed on both sides.
  task automatic test_steady_tail();
    drain_results();
    load_coefs(random_coef(), random_coef(), random_coef(), random_coef(), random_coef());
    write_reg(REG_ENABLE, 32'h0000_0001);
    jitter_on = 1'b0;
    repeat (150) send_pair(random_sample(), random_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: honors a long hold-off when one is requested, otherwise drops
  // ready in bursts of random length while jitter is enabled.
  initial begin : result_sink
    int hold_left;
    int idle_left;
    hold_left = 0;
    idle_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        hold_left = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        result_ch.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        idle_left = $urandom_range(1, 7) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is matched against the oldest owed pair, one field
  // at a time.
  always @(posedge clk) begin : result_check
    stereo_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (pending_outputs.size() == 0) begin
        log_failure($sformatf("result transfer with nothing owed: left %0d right %0d",
                              $signed(result_ch.left_out), $signed(result_ch.right_out)));
      end else begin
        want = pending_outputs.pop_front();
        if (result_ch.left_out !== want.left)
          log_failure($sformatf("left_out mismatch: expected %0d, got %0d",
                                $signed(want.left), $signed(result_ch.left_out)));
        if (result_ch.right_out !== want.right)
          log_failure($sformatf("right_out mismatch: expected %0d, got %0d",
                                $signed(want.right), $signed(result_ch.right_out)));
      end
    end
  end

  // Counts cycles in which nothing moves on either channel and no register is
  // written; a correct run never gets close to the limit.
  always @(posedge clk) begin : watchdog
    if (rst || cfg_write || (sample_ch.valid && sample_ch.ready)
        || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("FAIL stereo_biquad_filter");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sample_ch.valid = 1'b0;
    sample_ch.left_sample  = '0;
    sample_ch.right_sample = '0;
    error_count = 0;
    quiet_cycles = 0;
    jitter_on = 1'b0;
    sink_hold_cycles = 0;

    // Shadow state as the block comes out of reset: filter off, unity b0.
    filter_on = 1'b0;
    b0 = COEF_B0_RESET;
    b1 = '0;
    b2 = '0;
    a1 = '0;
    a2 = '0;
    left_hist  = '{default: '0};
    right_hist = '{default: '0};

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    test_reset_passthrough();
    test_unity_gain();
    test_round_half_up();
    test_saturation();
    test_history_across_bypass();
    test_spare_indexes();
    test_output_backpressure();
    test_sender_pause();
    test_random_phases();
    test_steady_tail();

    // Let the last results arrive, then watch a little longer for strays.
    drain_results();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("PASS stereo_biquad_filter");
    end else begin
      $display("FAIL stereo_biquad_filter");
    end
    $finish;
  end

endmodule
